// File: hdl/sajr_pkg.sv
`default_nettype none
package sajr_pkg;

	localparam int SAMPLE_BITS     = 8;
	localparam int COUNT_BITS_DEF  = 8;
	localparam int PHASE_W         = 7;
	localparam int OFF_W           = 6;
	localparam int IDX_W           = $clog2(SAMPLE_BITS);
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 8;
	localparam int IN_W            = 8;
	localparam int OUT_W           = 56;

	localparam logic [PHASE_W-1:0] PHASE_IDLE  = 7'd0;
	localparam logic [PHASE_W-1:0] PHASE_FIRST = 7'd1;
	localparam logic [PHASE_W-1:0] CONV_LEN    = 7'd39;
	localparam logic [PHASE_W-1:0] GAP_PHASE   = 7'd40;
	localparam logic [PHASE_W-1:0] Y_FIRST     = 7'd41;
	localparam logic [PHASE_W-1:0] LAST_PHASE  = 7'd79;

	localparam logic [OFF_W-1:0] CMD_LEN      = 6'd7;
	localparam logic [OFF_W-1:0] MUX_OFF_A    = 6'd2;
	localparam logic [OFF_W-1:0] MUX_OFF_B    = 6'd3;
	localparam logic [OFF_W-1:0] CHAN_OFF     = 6'd4;
	localparam logic [OFF_W-1:0] MSB_FIRST    = 6'd8;
	localparam logic [OFF_W-1:0] MSB_LAST     = 6'd22;
	localparam logic [OFF_W-1:0] LSB_LAST     = 6'd36;

	localparam logic [CFG_IDX_W-1:0] CFG_MUX_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_CHANNEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_CHANNEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 3'd4;

	localparam logic [SAMPLE_BITS-1:0] LOW_LIMIT_RST  = 8'd1;
	localparam logic [SAMPLE_BITS-1:0] HIGH_LIMIT_RST = 8'd254;

endpackage
`default_nettype wire

// File: hdl/serial_adc_joystick_reader.sv
// A result beat appears on the master side in the cycle after its input beat is taken.
// Throughput: one beat per cycle when not stalled; the sequencer steps once per input beat.
// A stalled master side holds the slave side only when the output register is full.
// Reset (arst_n low, asynchronous) returns the sequencer to idle, clears the sample words
// and direction counters, empties the output register and loads the register defaults.
`default_nettype none
module serial_adc_joystick_reader #(
	parameter int COUNT_BITS = sajr_pkg::COUNT_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// start_poll, data_pin, zero fill
	input  wire logic [sajr_pkg::IN_W-1:0]        s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// select_level, clock_level, data_out_level, data_drive, poll_done, x_sample, y_sample,
	// samples_agree, left_count, right_count, down_count, up_count, zero fill
	output logic [sajr_pkg::OUT_W-1:0]            m_tdata,
	input  wire logic                             cfg_we,
	input  wire logic [sajr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sajr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sajr_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic                   mux_mode_q, x_chan_q, y_chan_q;
	logic [SAMPLE_BITS-1:0] low_limit_q, high_limit_q;
	logic [PHASE_W-1:0]     phase_q;
	logic [SAMPLE_BITS-1:0] x_msb_q, x_lsb_q, y_msb_q, y_lsb_q;
	logic [COUNT_BITS-1:0]  cnt_q [4];
	logic                   m_tvalid_q;
	logic [OUT_W-1:0]       m_tdata_q;

	logic                   accept, start, din;
	logic [PHASE_W-1:0]     ph, phase_n;
	logic                   in_x, in_y, conv, chan;
	logic [OFF_W-1:0]       off, lsb_off;
	logic [IDX_W-1:0]       lsb_idx;
	logic                   cs, sclk, dout, drv, done, agree, take_msb, take_lsb;
	logic [SAMPLE_BITS-1:0] msb_w, lsb_w, msb_n, lsb_n;
	logic [SAMPLE_BITS-1:0] x_msb_n, x_lsb_n, y_msb_n, y_lsb_n;
	logic [COUNT_BITS-1:0]  cnt_n [4];
	logic [3:0]             hit;
	logic [COUNT_BITS+7:0]  cnt_ext [4];
	logic [OUT_W-1:0]       result;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign start    = s_tdata[0];
	assign din      = s_tdata[1];
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		if (phase_q == PHASE_IDLE || phase_q > LAST_PHASE) begin
			ph = start ? PHASE_FIRST : PHASE_IDLE;
		end else begin
			ph = phase_q;
		end
		in_x = (ph >= PHASE_FIRST) && (ph <= CONV_LEN);
		in_y = (ph >= Y_FIRST) && (ph <= LAST_PHASE);
		conv = in_x || in_y;
		off  = in_x ? 6'(ph - PHASE_FIRST) : 6'(ph - Y_FIRST);
		chan = in_x ? x_chan_q : y_chan_q;

		cs   = !conv;
		sclk = conv && off[0];
		drv  = conv && (off < CMD_LEN);
		if (!drv) begin
			dout = 1'b0;
		end else if (off == MUX_OFF_A || off == MUX_OFF_B) begin
			dout = mux_mode_q;
		end else if (off == CHAN_OFF) begin
			dout = chan;
		end else begin
			dout = 1'b1;
		end

		if (ph == PHASE_FIRST && phase_q != PHASE_FIRST) begin
			x_msb_n = '0;
			x_lsb_n = '0;
			y_msb_n = '0;
			y_lsb_n = '0;
		end else begin
			x_msb_n = x_msb_q;
			x_lsb_n = x_lsb_q;
			y_msb_n = y_msb_q;
			y_lsb_n = y_lsb_q;
		end

		msb_w    = in_x ? x_msb_n : y_msb_n;
		lsb_w    = in_x ? x_lsb_n : y_lsb_n;
		take_msb = conv && !off[0] && (off >= MSB_FIRST) && (off <= MSB_LAST);
		take_lsb = conv && !off[0] && (off >= MSB_LAST) && (off <= LSB_LAST);
		lsb_off  = off - MSB_LAST;
		lsb_idx  = lsb_off[IDX_W:1];
		msb_n    = take_msb ? {msb_w[SAMPLE_BITS-2:0], din} : msb_w;
		lsb_n    = lsb_w;
		if (take_lsb) begin
			lsb_n[lsb_idx] = lsb_w[lsb_idx] | din;
		end
		if (in_x) begin
			x_msb_n = msb_n;
			x_lsb_n = lsb_n;
		end else if (in_y) begin
			y_msb_n = msb_n;
			y_lsb_n = lsb_n;
		end

		agree = (x_msb_n == x_lsb_n) && (y_msb_n == y_lsb_n);
		done  = (ph == LAST_PHASE);
		hit[0] = x_msb_n < low_limit_q;
		hit[1] = x_msb_n > high_limit_q;
		hit[2] = y_msb_n < low_limit_q;
		hit[3] = y_msb_n > high_limit_q;
		for (int i = 0; i < 4; i++) begin
			if (done && agree) begin
				cnt_n[i] = !hit[i] ? '0 :
					(cnt_q[i] == COUNT_MAX) ? COUNT_MAX : cnt_q[i] + 1'b1;
			end else begin
				cnt_n[i] = cnt_q[i];
			end
			cnt_ext[i] = {8'd0, cnt_n[i]};
		end

		if (done || ph == PHASE_IDLE) begin
			phase_n = PHASE_IDLE;
		end else begin
			phase_n = ph + 1'b1;
		end

		result = {2'b00, cnt_ext[3][7:0], cnt_ext[2][7:0], cnt_ext[1][7:0], cnt_ext[0][7:0],
			agree, y_msb_n, x_msb_n, done, drv, dout, sclk, cs};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mux_mode_q   <= 1'b0;
			x_chan_q     <= 1'b0;
			y_chan_q     <= 1'b1;
			low_limit_q  <= LOW_LIMIT_RST;
			high_limit_q <= HIGH_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MUX_MODE:   mux_mode_q   <= cfg_data[0];
				CFG_X_CHANNEL:  x_chan_q     <= cfg_data[0];
				CFG_Y_CHANNEL:  y_chan_q     <= cfg_data[0];
				CFG_LOW_LIMIT:  low_limit_q  <= cfg_data;
				CFG_HIGH_LIMIT: high_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_IDLE;
			x_msb_q <= '0;
			x_lsb_q <= '0;
			y_msb_q <= '0;
			y_lsb_q <= '0;
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (accept) begin
			phase_q <= phase_n;
			x_msb_q <= x_msb_n;
			x_lsb_q <= x_lsb_n;
			y_msb_q <= y_msb_n;
			y_lsb_q <= y_lsb_n;
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= cnt_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= result;
		end
	end

endmodule
`default_nettype wire

// File: hdl/sajr_checker.sv
`default_nettype none
module sajr_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [sajr_pkg::OUT_W-1:0]       m_tdata
);
	// A stalled result beat must hold its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Every accepted input beat yields a result beat in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("result beat missing after accepted input beat");

	// With chip select high the bus is parked: clock low and data released.
	a_parked: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[1] && !m_tdata[3] && !m_tdata[2])
		else $error("bus not parked while deselected");

	// A finished read happens with the converter still selected.
	a_done_sel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> !m_tdata[0] && !m_tdata[3])
		else $error("read completed outside a conversion");

endmodule

bind serial_adc_joystick_reader sajr_checker u_sajr_checker (.*);
`default_nettype wire

// File: tb/sv/adc_read_checker.sv
module adc_read_checker #(
	parameter int COUNT_BITS = sajr_pkg::COUNT_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	input  wire logic                             s_tready,
	// start_poll, data_pin, zero fill
	input  wire logic [sajr_pkg::IN_W-1:0]        s_tdata,
	input  wire logic                             m_tvalid,
	input  wire logic                             m_tready,
	// select_level, clock_level, data_out_level, data_drive, poll_done, x_sample, y_sample,
	// samples_agree, left_count, right_count, down_count, up_count, zero fill
	input  wire logic [sajr_pkg::OUT_W-1:0]       m_tdata,
	input  wire logic                             cfg_we,
	input  wire logic [sajr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sajr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                                    fail_count,
	output int                                    pending,
	output int                                    beats_seen,
	output int                                    polls_seen,
	output int                                    agree_polls
);
	import sajr_pkg::*;

	typedef struct packed {
		logic [7:0] up;
		logic [7:0] down;
		logic [7:0] right;
		logic [7:0] left;
		logic       agree;
		logic [7:0] y;
		logic [7:0] x;
		logic       done;
		logic       drive;
		logic       dout;
		logic       sclk;
		logic       sel;
	} pin_result_t;

	localparam int RES_W = $bits(pin_result_t);

	logic [PHASE_W-1:0]    seq_phase;
	logic [7:0]            x_msb, x_lsb, y_msb, y_lsb;
	logic [COUNT_BITS-1:0] dir_count [4];
	logic                  mux_bit, x_chan, y_chan;
	logic [7:0]            lo_lim, hi_lim;
	pin_result_t           due_results [$];
	pin_result_t           want_res, got_res;

	function automatic logic [COUNT_BITS-1:0] bump_count(logic [COUNT_BITS-1:0] c, logic hit);
		if (!hit)
			return '0;
		return (&c) ? c : c + 1'b1;
	endfunction

	task automatic drive_conv(input logic [OFF_W-1:0] o, input logic chan, input logic d,
			inout logic [7:0] msb, inout logic [7:0] lsb,
			output logic sclk, output logic dout, output logic drv);
		int idx;
		sclk = o[0];
		if (o < CMD_LEN) begin
			drv = 1'b1;
			if (o == MUX_OFF_A || o == MUX_OFF_B)
				dout = mux_bit;
			else if (o == CHAN_OFF)
				dout = chan;
			else
				dout = 1'b1;
		end else begin
			drv = 1'b0;
			dout = 1'b0;
			if (!o[0]) begin
				if (o >= MSB_FIRST && o <= MSB_LAST)
					msb = {msb[6:0], d};
				if (o >= MSB_LAST && o <= LSB_LAST) begin
					idx = int'(o - MSB_LAST) / 2;
					lsb[idx] = lsb[idx] | d;
				end
			end
		end
	endtask

	task automatic predict_beat(input logic start, input logic d);
		pin_result_t r;
		logic sclk, dout, drv;
		r = '0;
		r.sel = 1'b1;
		sclk = 1'b0;
		dout = 1'b0;
		drv = 1'b0;
		if (seq_phase == PHASE_IDLE || seq_phase > LAST_PHASE) begin
			seq_phase = PHASE_IDLE;
			if (start) begin
				seq_phase = PHASE_FIRST;
				x_msb = '0;
				x_lsb = '0;
				y_msb = '0;
				y_lsb = '0;
			end
		end
		if (seq_phase >= PHASE_FIRST && seq_phase <= CONV_LEN) begin
			r.sel = 1'b0;
			drive_conv(OFF_W'(seq_phase - PHASE_FIRST), x_chan, d, x_msb, x_lsb, sclk, dout, drv);
		end else if (seq_phase >= Y_FIRST && seq_phase <= LAST_PHASE) begin
			r.sel = 1'b0;
			drive_conv(OFF_W'(seq_phase - Y_FIRST), y_chan, d, y_msb, y_lsb, sclk, dout, drv);
		end
		r.sclk = sclk;
		r.dout = dout;
		r.drive = drv;
		r.agree = (x_msb == x_lsb) && (y_msb == y_lsb);
		if (seq_phase == LAST_PHASE) begin
			r.done = 1'b1;
			polls_seen++;
			if (r.agree) begin
				agree_polls++;
				dir_count[0] = bump_count(dir_count[0], x_msb < lo_lim);
				dir_count[1] = bump_count(dir_count[1], x_msb > hi_lim);
				dir_count[2] = bump_count(dir_count[2], y_msb < lo_lim);
				dir_count[3] = bump_count(dir_count[3], y_msb > hi_lim);
			end
			seq_phase = PHASE_IDLE;
		end else if (seq_phase != PHASE_IDLE) begin
			seq_phase = seq_phase + 1'b1;
		end
		r.x = x_msb;
		r.y = y_msb;
		r.left = 8'(dir_count[0]);
		r.right = 8'(dir_count[1]);
		r.down = 8'(dir_count[2]);
		r.up = 8'(dir_count[3]);
		due_results.push_back(r);
	endtask

	task automatic note_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_phase = PHASE_IDLE;
			x_msb = '0;
			x_lsb = '0;
			y_msb = '0;
			y_lsb = '0;
			foreach (dir_count[i])
				dir_count[i] = '0;
			mux_bit = 1'b0;
			x_chan = 1'b0;
			y_chan = 1'b1;
			lo_lim = LOW_LIMIT_RST;
			hi_lim = HIGH_LIMIT_RST;
			due_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got_res = m_tdata[RES_W-1:0];
				if (due_results.size() == 0) begin
					fail_count++;
					$display("%0t: result beat %h arrived with nothing expected", $time, m_tdata);
				end else begin
					want_res = due_results.pop_front();
					note_field("select_level", 8'(want_res.sel), 8'(got_res.sel));
					note_field("clock_level", 8'(want_res.sclk), 8'(got_res.sclk));
					note_field("data_out_level", 8'(want_res.dout), 8'(got_res.dout));
					note_field("data_drive", 8'(want_res.drive), 8'(got_res.drive));
					note_field("poll_done", 8'(want_res.done), 8'(got_res.done));
					note_field("x_sample", want_res.x, got_res.x);
					note_field("y_sample", want_res.y, got_res.y);
					note_field("samples_agree", 8'(want_res.agree), 8'(got_res.agree));
					note_field("left_count", want_res.left, got_res.left);
					note_field("right_count", want_res.right, got_res.right);
					note_field("down_count", want_res.down, got_res.down);
					note_field("up_count", want_res.up, got_res.up);
					note_field("zero fill", '0, 8'(m_tdata[OUT_W-1:RES_W]));
				end
			end
			if (s_tvalid && s_tready) begin
				beats_seen++;
				predict_beat(s_tdata[0], s_tdata[1]);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MUX_MODE: mux_bit = cfg_data[0];
					CFG_X_CHANNEL: x_chan = cfg_data[0];
					CFG_Y_CHANNEL: y_chan = cfg_data[0];
					CFG_LOW_LIMIT: lo_lim = cfg_data;
					CFG_HIGH_LIMIT: hi_lim = cfg_data;
					default: ;
				endcase
			end
		end
		pending = due_results.size();
	end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
	import sajr_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  m_tready = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_MUX_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	wire                   s_tready;
	wire                   m_tvalid;
	wire  [OUT_W-1:0]      m_tdata;

	int fail_count, pending, beats_seen, polls_seen, agree_polls;
	bit tx_gaps = 1'b0;
	bit rx_gaps = 1'b0;
	bit rx_hold = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	serial_adc_joystick_reader dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	adc_read_checker read_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .beats_seen(beats_seen),
		.polls_seen(polls_seen), .agree_polls(agree_polls)
	);

	// The long hold-off lets the output side back up until the input side stalls.
	always begin
		@(negedge clk);
		if (rx_hold) begin
			m_tready <= 1'b0;
			repeat (120) @(negedge clk);
			rx_hold = 1'b0;
		end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		m_tready <= 1'b1;
	end

	task automatic send_beat(input logic start, input logic d);
		@(negedge clk);
		if (tx_gaps && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({d, start});
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_beat(1'b0, 1'($urandom_range(0, 1)));
	endtask

	// A well-formed read presents each sample MSB-first and then LSB-first;
	// a broken one flips a single data bit that only one of the two words sees.
	task automatic send_poll(input logic [7:0] xv, input logic [7:0] yv, input bit broken);
		int flip_at, k, o;
		logic d;
		logic [7:0] v;
		flip_at = 0;
		if (broken) begin
			k = $urandom_range(0, 13);
			if (k >= 7)
				k++;
			flip_at = ($urandom_range(0, 1) ? int'(Y_FIRST) : int'(PHASE_FIRST)) + 8 + 2 * k;
		end
		for (int p = 1; p <= int'(LAST_PHASE); p++) begin
			d = 1'($urandom_range(0, 1));
			if (p != int'(GAP_PHASE)) begin
				v = (p <= int'(CONV_LEN)) ? xv : yv;
				o = (p <= int'(CONV_LEN)) ? p - int'(PHASE_FIRST) : p - int'(Y_FIRST);
				if (o % 2 == 0 && o >= int'(MSB_FIRST) && o <= int'(MSB_LAST))
					d = v[7 - (o - int'(MSB_FIRST)) / 2];
				else if (o % 2 == 0 && o > int'(MSB_LAST) && o <= int'(LSB_LAST))
					d = v[(o - int'(MSB_LAST)) / 2];
			end
			if (p == flip_at)
				d = !d;
			send_beat(p == 1 ? 1'b1 : 1'($urandom_range(0, 1)), d);
		end
	endtask

	function automatic logic [7:0] pick_sample(input logic [7:0] lo, input logic [7:0] hi);
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'(lo - 1 + $urandom_range(0, 2));
			3: return 8'(hi - 1 + $urandom_range(0, 2));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic run_polls(input int n, input logic [7:0] lo, input logic [7:0] hi);
		repeat (n) begin
			send_noise($urandom_range(0, 3));
			send_poll(pick_sample(lo, hi), pick_sample(lo, hi), $urandom_range(0, 4) == 0);
		end
	endtask

	task automatic write_settings(input logic mux, input logic xc, input logic yc,
			input logic [7:0] lo, input logic [7:0] hi);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MUX_MODE;
		cfg_data <= CFG_DATA_W'(mux);
		@(negedge clk);
		cfg_index <= CFG_X_CHANNEL;
		cfg_data <= CFG_DATA_W'(xc);
		@(negedge clk);
		cfg_index <= CFG_Y_CHANNEL;
		cfg_data <= CFG_DATA_W'(yc);
		@(negedge clk);
		cfg_index <= CFG_LOW_LIMIT;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= CFG_HIGH_LIMIT;
		cfg_data <= hi;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [7:0] lo, hi;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_beat(1'b0, 1'b0);
		send_beat(1'b0, 1'b1);
		send_poll(8'd0, 8'd255, 1'b0);
		send_poll(8'h5a, 8'ha5, 1'b1);

		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		run_polls(1, LOW_LIMIT_RST, HIGH_LIMIT_RST);

		write_settings(1'b1, 1'b1, 1'b0, 8'd0, 8'd255);
		rx_hold = 1'b1;
		run_polls(1, 8'd0, 8'd255);

		lo = 8'($urandom_range(0, 255));
		hi = 8'($urandom_range(0, 255));
		write_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), lo, hi);
		run_polls(1, lo, hi);

		// With the limits crossed, an agreeing read moves all four counters up.
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		write_settings(1'b0, 1'b1, 1'b1, 8'd255, 8'd0);
		send_poll(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)), 1'b0);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("Covered %0d beats and %0d complete reads (%0d with agreeing words)",
			beats_seen, polls_seen, agree_polls);
		$display("over four register settings, random idling and a long output stall.");
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule
